// File: rtl/framebuffer_to_argb_unpacker_defines.svh
// Assertion macros used by the framebuffer unpacker core.
`ifndef FRAMEBUFFER_TO_ARGB_UNPACKER_DEFINES_SVH
`define FRAMEBUFFER_TO_ARGB_UNPACKER_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define FBAU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the following cycle.
`define FBAU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/fbau_pkg.sv
// Shared types, constants and register codes of the framebuffer unpacker.
package fbau_pkg;

    // Panel and memory limits
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_PITCH  = 16384;

    // Field and register widths
    localparam int BYTE_W      = 8;
    localparam int ARGB_W      = 32;
    localparam int POS_W       = 12;
    localparam int FMT_W       = 2;
    localparam int DIM_W       = 13;
    localparam int PITCH_W     = 15;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 15;
    localparam int PHASE_W     = 2;
    localparam int PARTIAL_W   = 24;
    localparam int RBC_W       = 14;
    localparam int COL_W       = 14;
    localparam int TDATA_OUT_W = 56;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_PITCH_BYTES = 2'd3;

    // Pixel formats
    typedef enum logic [FMT_W-1:0] {
        FMT_RGB444   = 2'd0,
        FMT_RGB565   = 2'd1,
        FMT_BGR888   = 2'd2,
        FMT_XRGB8888 = 2'd3
    } fmt_t;

    // Register reset values
    localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = 13'd176;
    localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = 13'd208;
    localparam logic [PITCH_W-1:0] RST_ROW_PITCH    = 15'd704;

    // Reciprocal constants for 5 and 6 bit to 8 bit floor scaling
    localparam int unsigned R5_SHIFT = 18;
    localparam int unsigned R5_RECIP = (2**18 + 30) / 31;
    localparam int unsigned R5_MUL   = 255 * R5_RECIP;
    localparam int unsigned G6_SHIFT = 20;
    localparam int unsigned G6_RECIP = (2**20 + 62) / 63;
    localparam int unsigned G6_MUL   = 255 * G6_RECIP;

    // Effective configuration after clamping
    typedef struct packed {
        fmt_t               fmt;
        logic [PHASE_W-1:0] last_phase;
        logic [POS_W-1:0]   width_m1;
        logic [DIM_W-1:0]   height;
        logic [POS_W-1:0]   height_m1;
        logic [PITCH_W-1:0] row_bytes;
        logic [PITCH_W-1:0] pitch;
    } cfg_t;

    // Input request held in the input register
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] fb_byte;
    } in_req_t;

endpackage

// File: rtl/fbau_cfg_regs.sv
// Configuration registers and clamped effective settings.
module fbau_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fbau_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fbau_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output fbau_pkg::cfg_t                    cfg_eff
);
    import fbau_pkg::*;

    fmt_t               fmt_reg;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [PITCH_W-1:0] pitch_reg;

    logic [DIM_W-1:0]   width_c;
    logic [DIM_W-1:0]   height_c;
    logic [PITCH_W-1:0] pitch_c;
    logic [PITCH_W-1:0] width_x;
    logic [PITCH_W-1:0] row_bytes;

    // Write registers by index
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            fmt_reg    <= FMT_XRGB8888;
            width_reg  <= RST_FRAME_WIDTH;
            height_reg <= RST_FRAME_HEIGHT;
            pitch_reg  <= RST_ROW_PITCH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PIXEL_FORMAT:    fmt_reg    <= fmt_t'(cfg_wdata[FMT_W-1:0]);
                REG_FRAME_WIDTH:     width_reg  <= cfg_wdata[DIM_W-1:0];
                REG_FRAME_HEIGHT:    height_reg <= cfg_wdata[DIM_W-1:0];
                REG_ROW_PITCH_BYTES: pitch_reg  <= cfg_wdata[PITCH_W-1:0];
                default:             ;
            endcase
        end
    end

    // Clamp width, height and pitch; derive pixel bytes per row
    always_comb
    begin
        if (width_reg == '0)
            width_c = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_WIDTH))
            width_c = DIM_W'(MAX_WIDTH);
        else
            width_c = width_reg;

        if (height_reg == '0)
            height_c = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            height_c = DIM_W'(MAX_HEIGHT);
        else
            height_c = height_reg;

        width_x = PITCH_W'(width_c);
        case (fmt_reg)
            FMT_RGB444, FMT_RGB565: row_bytes = width_x << 1;
            FMT_BGR888:             row_bytes = width_x + (width_x << 1);
            default:                row_bytes = width_x << 2;
        endcase

        if (pitch_reg == '0)
            pitch_c = PITCH_W'(1);
        else if (pitch_reg > PITCH_W'(MAX_PITCH))
            pitch_c = PITCH_W'(MAX_PITCH);
        else
            pitch_c = pitch_reg;
        if (pitch_c < row_bytes)
            pitch_c = row_bytes;

        cfg_eff.fmt       = fmt_reg;
        case (fmt_reg)
            FMT_RGB444, FMT_RGB565: cfg_eff.last_phase = 2'd1;
            FMT_BGR888:             cfg_eff.last_phase = 2'd2;
            default:                cfg_eff.last_phase = 2'd3;
        endcase
        cfg_eff.width_m1  = POS_W'(width_c - DIM_W'(1));
        cfg_eff.height    = height_c;
        cfg_eff.height_m1 = POS_W'(height_c - DIM_W'(1));
        cfg_eff.row_bytes = row_bytes;
        cfg_eff.pitch     = pitch_c;
    end

endmodule

// File: rtl/fbau_pixel_conv.sv
// Conversion of a gathered pixel word to opaque ARGB8888.
module fbau_pixel_conv (
    input  fbau_pkg::fmt_t                   fmt,
    input  logic [fbau_pkg::PARTIAL_W-1:0]   word,
    output logic [fbau_pkg::ARGB_W-1:0]      argb
);
    import fbau_pkg::*;

    logic [26:0] r5_scaled;
    logic [28:0] g6_scaled;
    logic [26:0] b5_scaled;
    logic [7:0]  r8;
    logic [7:0]  g8;
    logic [7:0]  b8;

    // Scale 565 channels by 255/31 and 255/63, rounded down
    assign r5_scaled = 27'(word[15:11]) * 27'(R5_MUL);
    assign g6_scaled = 29'(word[10:5]) * 29'(G6_MUL);
    assign b5_scaled = 27'(word[4:0]) * 27'(R5_MUL);

    // Pick channels by format
    always_comb
    begin
        case (fmt)
            FMT_RGB444:
            begin
                r8 = {word[11:8], word[11:8]};
                g8 = {word[7:4], word[7:4]};
                b8 = {word[3:0], word[3:0]};
            end
            FMT_RGB565:
            begin
                r8 = r5_scaled[R5_SHIFT+7:R5_SHIFT];
                g8 = g6_scaled[G6_SHIFT+7:G6_SHIFT];
                b8 = b5_scaled[R5_SHIFT+7:R5_SHIFT];
            end
            default:
            begin
                r8 = word[23:16];
                g8 = word[15:8];
                b8 = word[7:0];
            end
        endcase
        argb = {8'hFF, r8, g8, b8};
    end

endmodule

// File: rtl/fbau_unpack_core.sv
// Byte gathering, row and frame counters and the result register.
`include "framebuffer_to_argb_unpacker_defines.svh"

module fbau_unpack_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  fbau_pkg::cfg_t                     cfg_eff,
    input  fbau_pkg::in_req_t                  in_req,
    output logic                               take,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fbau_pkg::TDATA_OUT_W-1:0]   m_tdata,
    output logic                               m_tlast,
    output logic                               m_tuser
);
    import fbau_pkg::*;

    logic [PHASE_W-1:0]   phase_reg,   phase_next;
    logic [PARTIAL_W-1:0] partial_reg, partial_next;
    logic [RBC_W-1:0]     rbc_reg,     rbc_next;
    logic [COL_W-1:0]     col_reg,     col_next;
    logic [POS_W-1:0]     row_reg,     row_next;

    logic                 out_valid_reg;
    logic [ARGB_W-1:0]    out_argb_reg;
    logic [POS_W-1:0]     out_col_reg;
    logic [POS_W-1:0]     out_row_reg;
    logic                 out_eor_reg;
    logic                 out_eof_reg;

    logic                 in_data;
    logic                 emit;
    logic                 eor;
    logic                 eof;
    logic                 row_wrap;
    logic [PARTIAL_W-1:0] byte_shifted;
    logic [PARTIAL_W-1:0] word;
    logic [ARGB_W-1:0]    argb;
    logic [PITCH_W-1:0]   rbc_inc;
    logic [DIM_W-1:0]     row_inc;

    // Advance when a request is held and the result register can load
    assign take = in_req.valid && (!out_valid_reg || m_tready);

    // Place the byte at its position in the pixel
    always_comb
    begin
        case (phase_reg)
            2'd0:    byte_shifted = PARTIAL_W'(in_req.fb_byte);
            2'd1:    byte_shifted = PARTIAL_W'(in_req.fb_byte) << 8;
            2'd2:    byte_shifted = PARTIAL_W'(in_req.fb_byte) << 16;
            default: byte_shifted = '0;
        endcase
    end

    assign in_data = PITCH_W'(rbc_reg) < cfg_eff.row_bytes;
    assign emit    = in_data && (phase_reg >= cfg_eff.last_phase);
    assign word    = partial_reg | byte_shifted;
    assign eor     = col_reg >= COL_W'(cfg_eff.width_m1);
    assign eof     = eor && (row_reg >= cfg_eff.height_m1);
    assign rbc_inc = PITCH_W'(rbc_reg) + PITCH_W'(1);
    assign row_inc = DIM_W'(row_reg) + DIM_W'(1);
    assign row_wrap = rbc_inc >= cfg_eff.pitch;

    fbau_pixel_conv u_conv (
        .fmt  (cfg_eff.fmt),
        .word (word),
        .argb (argb)
    );

    // Next pixel, row and frame state
    always_comb
    begin
        phase_next   = phase_reg;
        partial_next = partial_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        rbc_next     = rbc_inc[RBC_W-1:0];

        if (emit)
        begin
            col_next     = col_reg + COL_W'(1);
            phase_next   = '0;
            partial_next = '0;
        end
        else if (in_data)
        begin
            partial_next = word;
            phase_next   = phase_reg + PHASE_W'(1);
        end

        if (row_wrap)
        begin
            rbc_next     = '0;
            col_next     = '0;
            phase_next   = '0;
            partial_next = '0;
            if (row_inc >= cfg_eff.height)
                row_next = '0;
            else
                row_next = row_inc[POS_W-1:0];
        end
    end

    // Hold state until a request advances
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            partial_reg <= '0;
            rbc_reg     <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            partial_reg <= partial_next;
            rbc_reg     <= rbc_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take && emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // Load the result payload
    always_ff @(posedge clk) begin
        if (take && emit)
        begin
            out_argb_reg <= argb;
            out_col_reg  <= col_reg[POS_W-1:0];
            out_row_reg  <= row_reg;
            out_eor_reg  <= eor;
            out_eof_reg  <= eof;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_row_reg, out_col_reg, out_argb_reg};
    assign m_tlast  = out_eor_reg;
    assign m_tuser  = out_eof_reg;

    `FBAU_ASSERT_NXT(a_emit_loads, take && emit, out_valid_reg, "result not loaded")
    `FBAU_ASSERT_NXT(a_emit_clears, take && emit, phase_reg == '0 && partial_reg == '0, "pixel not cleared")
    `FBAU_ASSERT_NXT(a_row_wrap, take && row_wrap, col_reg == '0 && rbc_reg == '0, "row not restarted")
    `FBAU_ASSERT_IMP(a_eof_eor, out_valid_reg && out_eof_reg, out_eor_reg, "frame end without row end")
    `FBAU_ASSERT_IMP(a_stall_no_take, out_valid_reg && !m_tready, !take, "advance into full result")

endmodule

// File: rtl/framebuffer_to_argb_unpacker.sv
// Top level: framebuffer byte stream to ARGB8888 pixel stream.
// Path: a byte is registered at the input, and the pixel its last byte completes
// is loaded into the result register when that byte leaves the input register.
// Throughput: one byte per cycle unless the output stalls; a 2, 3 or 4 byte pixel
// is built by the single-pass gather and convert stage between the two registers.
// Reset (rst_n low, asynchronous) restores the format, size and pitch registers to their
// defaults, clears the counters and the pixel being gathered, and empties both registers.
module framebuffer_to_argb_unpacker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [fbau_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fbau_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fbau_pkg::BYTE_W-1:0]        s_tdata,   // [7:0] fb_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fbau_pkg::TDATA_OUT_W-1:0]   m_tdata,   // [31:0] pixel_argb,
                                                          // [43:32] pixel_column,
                                                          // [55:44] pixel_row
    output logic                               m_tlast,   // end_of_row
    output logic                               m_tuser    // [0] end_of_frame
);
    import fbau_pkg::*;

    cfg_t              cfg_eff;
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    in_req_t           in_req;
    logic              take;

    fbau_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg_eff   (cfg_eff)
    );

    // Accept a request when the input register is empty or draining
    assign s_tready = !in_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk) begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata;
    end

    assign in_req.valid   = in_valid_reg;
    assign in_req.fb_byte = in_byte_reg;

    fbau_unpack_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_eff  (cfg_eff),
        .in_req   (in_req),
        .take     (take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// File: test/argb_pixel_checker.sv
// Checker for the framebuffer unpacker: tracks its registers, predicts pixels, compares output.
module argb_pixel_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [fbau_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fbau_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [fbau_pkg::BYTE_W-1:0]      s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [fbau_pkg::TDATA_OUT_W-1:0] m_tdata,
    input  logic                             m_tlast,
    input  logic                             m_tuser,
    output logic [31:0]                      pixels_owed,
    output logic [31:0]                      pixel_errors
);
    import fbau_pkg::*;

    typedef struct packed {
        logic [31:0] argb;
        logic [11:0] column;
        logic [11:0] row;
        logic        row_end;
        logic        frame_end;
    } pixel_t;

    // Register copies, reset values
    fmt_t               fmt_reg    = FMT_XRGB8888;
    logic [DIM_W-1:0]   width_reg  = RST_FRAME_WIDTH;
    logic [DIM_W-1:0]   height_reg = RST_FRAME_HEIGHT;
    logic [PITCH_W-1:0] pitch_reg  = RST_ROW_PITCH;

    // Scan position and the pixel being gathered
    int unsigned gather_idx   = 0;
    int unsigned gather_bytes = 0;
    int unsigned row_byte_pos = 0;
    int unsigned column_pos   = 0;
    int unsigned row_pos      = 0;

    pixel_t      owed_pixels [$];
    int unsigned error_total = 0;

    assign pixel_errors = error_total;

    function automatic int unsigned bytes_of(fmt_t f);
        if (f == FMT_RGB444 || f == FMT_RGB565)
            return 2;
        return (f == FMT_BGR888) ? 3 : 4;
    endfunction

    // Zero counts as one, anything above the limit as the limit
    function automatic int unsigned bounded(int unsigned v, int unsigned hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [31:0] expand_rgb(fmt_t f, logic [23:0] v);
        int unsigned r;
        int unsigned g;
        int unsigned b;
        case (f)
            FMT_RGB444:
            begin
                r = v[11:8] * 17;
                g = v[7:4] * 17;
                b = v[3:0] * 17;
            end
            FMT_RGB565:
            begin
                r = v[15:11] * 255 / 31;
                g = v[10:5] * 255 / 63;
                b = v[4:0] * 255 / 31;
            end
            default:
            begin
                r = v[23:16];
                g = v[15:8];
                b = v[7:0];
            end
        endcase
        return {8'hFF, r[7:0], g[7:0], b[7:0]};
    endfunction

    // Advance the scan by one framebuffer byte, queue the pixel it completes
    task automatic absorb_byte(input logic [7:0] fb_byte);
        int unsigned bpp;
        int unsigned width;
        int unsigned height;
        int unsigned row_bytes;
        int unsigned pitch;
        int unsigned shift;
        int unsigned word;
        pixel_t      px;
        bpp       = bytes_of(fmt_reg);
        width     = bounded(width_reg, MAX_WIDTH);
        height    = bounded(height_reg, MAX_HEIGHT);
        row_bytes = width * bpp;
        pitch     = bounded(pitch_reg, MAX_PITCH);
        if (pitch < row_bytes)
            pitch = row_bytes;

        if (row_byte_pos < row_bytes)
        begin
            if (gather_idx >= bpp - 1)
            begin
                shift = (gather_idx > 2) ? 24 : gather_idx * 8;
                word  = gather_bytes;
                if (shift < 24)
                    word = word | (int'(fb_byte) << shift);
                px.argb      = expand_rgb(fmt_reg, word[23:0]);
                px.column    = column_pos[11:0];
                px.row       = row_pos[11:0];
                px.row_end   = (column_pos >= width - 1);
                px.frame_end = px.row_end && (row_pos >= height - 1);
                owed_pixels  = {owed_pixels, px};
                column_pos   = (column_pos + 1) & 32'h3FFF;
                gather_idx   = 0;
                gather_bytes = 0;
            end
            else
            begin
                gather_bytes = (gather_bytes | (int'(fb_byte) << (gather_idx * 8))) & 32'hFF_FFFF;
                gather_idx   = (gather_idx + 1) & 32'h3;
            end
        end

        // Skip the padding up to the pitch, then start the next row
        row_byte_pos = (row_byte_pos + 1) & 32'hFFFF;
        if (row_byte_pos >= pitch)
        begin
            row_byte_pos = 0;
            column_pos   = 0;
            gather_idx   = 0;
            gather_bytes = 0;
            row_pos      = row_pos + 1;
            if (row_pos >= height)
                row_pos = 0;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            fmt_reg      = FMT_XRGB8888;
            width_reg    = RST_FRAME_WIDTH;
            height_reg   = RST_FRAME_HEIGHT;
            pitch_reg    = RST_ROW_PITCH;
            gather_idx   = 0;
            gather_bytes = 0;
            row_byte_pos = 0;
            column_pos   = 0;
            row_pos      = 0;
            owed_pixels.delete();
            pixels_owed <= 0;
        end
        else
        begin
            // Compare a delivered pixel with the oldest one owed
            if (m_tvalid && m_tready)
            begin
                if (owed_pixels.size() == 0)
                begin
                    $error("pixel delivered with none owed: tdata 0x%0h", m_tdata);
                    error_total++;
                end
                else
                begin
                    want = owed_pixels.pop_front();
                    check_field("pixel_argb", want.argb, m_tdata[31:0]);
                    check_field("pixel_column", 32'(want.column), 32'(m_tdata[43:32]));
                    check_field("pixel_row", 32'(want.row), 32'(m_tdata[55:44]));
                    check_field("end_of_row", 32'(want.row_end), 32'(m_tlast));
                    check_field("end_of_frame", 32'(want.frame_end), 32'(m_tuser));
                end
            end

            // Mirror register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PIXEL_FORMAT:    fmt_reg    = fmt_t'(cfg_wdata[FMT_W-1:0]);
                    REG_FRAME_WIDTH:     width_reg  = cfg_wdata[DIM_W-1:0];
                    REG_FRAME_HEIGHT:    height_reg = cfg_wdata[DIM_W-1:0];
                    REG_ROW_PITCH_BYTES: pitch_reg  = cfg_wdata[PITCH_W-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
                absorb_byte(s_tdata);

            pixels_owed <= owed_pixels.size();
        end
    end

endmodule

// File: test/tb.sv
// Testbench top: drives framebuffer bytes and panel settings into the unpacker, gives the verdict.
module tb;
    import fbau_pkg::*;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic [BYTE_W-1:0]      s_tdata   = '0;
    logic                   m_tready  = 1'b0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;
    logic [31:0]            pixels_owed;
    logic [31:0]            pixel_errors;

    int unsigned bytes_sent   = 0;
    int unsigned stranded     = 0;
    int unsigned tx_gap_pct   = 20;
    int unsigned rx_stall_pct = 20;
    bit          hold_output  = 1'b0;

    localparam int unsigned BYTE_TARGET = 1850;
    localparam int unsigned HOLD_CYCLES = 150;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    framebuffer_to_argb_unpacker dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    argb_pixel_checker pixel_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .pixels_owed (pixels_owed),
        .pixel_errors(pixel_errors)
    );

    // Offer one byte, with a random gap first, and hold it until accepted
    task automatic send_byte(input logic [7:0] fb_byte);
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= fb_byte;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    // Stop offering, wait for every owed pixel, then let the pipeline settle
    task automatic drain_pipeline();
        int unsigned waited;
        s_tvalid <= 1'b0;
        waited = 0;
        @(posedge clk);
        while (pixels_owed != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pixels_owed != 0)
        begin
            $error("pixels never delivered: %0d", pixels_owed);
            stranded++;
        end
        repeat (6) @(posedge clk);
    endtask

    // Output side: random stall bursts and one long hold-off
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_output)
            begin
                hold_output = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        #6000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        logic [7:0]  seq [$];
        int unsigned fmt_sel;
        int unsigned w;
        int unsigned h;
        int unsigned p;
        int unsigned eff_w;
        int unsigned row_sz;
        int unsigned n;
        int unsigned round_no;
        logic [3:0]  write_mask;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset format is 32-bit: the top byte must not show, alpha stays opaque
        seq = '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'h00, 8'hFF, 8'h55, 8'hFF};
        foreach (seq[i])
            send_byte(seq[i]);
        drain_pipeline();

        // 12-bit, zero width, height and pitch: one-pixel rows, every pixel ends the frame
        write_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_RGB444));
        write_reg(REG_FRAME_WIDTH, '0);
        write_reg(REG_FRAME_HEIGHT, '0);
        write_reg(REG_ROW_PITCH_BYTES, '0);
        cfg_we <= 1'b0;
        seq = '{8'hFF, 8'h0F, 8'hA5, 8'hF0};
        foreach (seq[i])
            send_byte(seq[i]);
        drain_pipeline();

        // 565 at both extremes, pitch far above its limit
        write_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_RGB565));
        write_reg(REG_FRAME_WIDTH, 15'd2);
        write_reg(REG_ROW_PITCH_BYTES, 15'h7FFF);
        cfg_we <= 1'b0;
        seq = '{8'hFF, 8'hFF, 8'h00, 8'h00};
        foreach (seq[i])
            send_byte(seq[i]);
        drain_pipeline();

        // 24-bit mid-row, oversized width and height, pitch below the row bytes
        write_reg(REG_PIXEL_FORMAT, {13'h1FFF, FMT_BGR888});
        write_reg(REG_FRAME_WIDTH, 15'h7FFF);
        write_reg(REG_FRAME_HEIGHT, 15'h7FFF);
        write_reg(REG_ROW_PITCH_BYTES, 15'd5);
        cfg_we <= 1'b0;
        seq = '{8'h12, 8'h34, 8'h56, 8'hFE, 8'h01, 8'h80};
        foreach (seq[i])
            send_byte(seq[i]);
        drain_pipeline();

        // Random panel settings and byte runs
        round_no = 0;
        while (bytes_sent < BYTE_TARGET)
        begin
            round_no++;
            if (bytes_sent > BYTE_TARGET - 300)
            begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: tx_gap_pct = 0;
                    1: tx_gap_pct = 10;
                    2: tx_gap_pct = 30;
                    default: tx_gap_pct = 60;
                endcase
                case ($urandom_range(0, 3))
                    0: rx_stall_pct = 0;
                    1: rx_stall_pct = 10;
                    2: rx_stall_pct = 30;
                    default: rx_stall_pct = 60;
                endcase
            end

            fmt_sel = $urandom_range(0, 3);
            case ($urandom_range(0, 19))
                0, 1:    w = 0;
                2:       w = $urandom_range(4096, 8191);
                3, 4:    w = $urandom_range(7, 40);
                default: w = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 19))
                0, 1:    h = 0;
                2:       h = $urandom_range(4096, 8191);
                3:       h = $urandom_range(5, 20);
                default: h = $urandom_range(1, 4);
            endcase
            eff_w  = (w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
            row_sz = eff_w * ((fmt_sel <= 1) ? 2 : fmt_sel + 1);
            case ($urandom_range(0, 19))
                10, 11, 12, 13: p = $urandom_range(0, row_sz);
                14, 15:         p = $urandom_range(16385, 32767);
                16, 17, 18, 19: p = $urandom_range(1, 64);
                default:        p = row_sz + $urandom_range(0, 3);
            endcase

            // Mostly a full reprogram, sometimes a partial one mid-frame
            write_mask = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'hF;
            if (write_mask[0])
                write_reg(REG_PIXEL_FORMAT, {13'($urandom), 2'(fmt_sel)});
            if (write_mask[1])
                write_reg(REG_FRAME_WIDTH, {2'($urandom), 13'(w)});
            if (write_mask[2])
                write_reg(REG_FRAME_HEIGHT, {2'($urandom), 13'(h)});
            if (write_mask[3])
                write_reg(REG_ROW_PITCH_BYTES, 15'(p));
            cfg_we <= 1'b0;

            // Once, starve the output while bytes keep coming
            if (round_no == 4)
            begin
                hold_output = 1'b1;
                tx_gap_pct  = 0;
            end

            n = $urandom_range(20, 110);
            if (n > BYTE_TARGET - bytes_sent)
                n = BYTE_TARGET - bytes_sent;
            repeat (n)
                send_byte(8'($urandom_range(0, 255)));
            drain_pipeline();
        end

        repeat (20) @(posedge clk);
        if (pixel_errors == 0 && stranded == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: framebuffer_to_argb_unpacker.f
+incdir+rtl
rtl/fbau_pkg.sv
rtl/fbau_cfg_regs.sv
rtl/fbau_pixel_conv.sv
rtl/fbau_unpack_core.sv
rtl/framebuffer_to_argb_unpacker.sv
test/argb_pixel_checker.sv
test/tb.sv
